@@ rtl/lcdt_pkg.sv @@
// Shared types, constants and the cell compare function for the damage tracker.
package lcdt_pkg;

    localparam int COLUMNS = 128;
    localparam int ROWS    = 64;
    localparam int LAYERS  = 3;
    localparam int PLANE   = ROWS * COLUMNS;
    localparam int PLANE_W = (PLANE > 1) ? $clog2(PLANE) : 1;
    localparam int CELL_W  = 50;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [7:0] GLYPH_NONE    = 8'h00;
    localparam logic [7:0] GLYPH_SPACE   = 8'h20;
    localparam logic [8:0] COLOR_DEFAULT = 9'h1FF;

    typedef struct packed {
        logic [8:0]  bg;
        logic [8:0]  fg;
        logic [31:0] glyph;
    } t_cell;

    function automatic t_cell clear_lead(t_cell c);
        t_cell r;
        r = c;
        r.glyph[7:0] = GLYPH_NONE;
        return r;
    endfunction

    function automatic logic cells_equal(t_cell a, t_cell b);
        logic eq;
        if (a.glyph[7:0] != b.glyph[7:0]) begin
            eq = 1'b0;
        end else if (a.glyph[7:0] == GLYPH_NONE) begin
            eq = 1'b1;
        end else if (a.glyph[15:8] != b.glyph[15:8]) begin
            eq = 1'b0;
        end else if (a.glyph[15:8] != GLYPH_NONE && a.glyph[23:16] != b.glyph[23:16]) begin
            eq = 1'b0;
        end else if (a.glyph[15:8] != GLYPH_NONE && a.glyph[23:16] != GLYPH_NONE
                     && a.glyph[31:24] != b.glyph[31:24]) begin
            eq = 1'b0;
        end else begin
            eq = (a.fg == b.fg && a.bg == b.bg)
                 || (a.glyph[7:0] == GLYPH_SPACE && a.bg == b.bg);
        end
        return eq;
    endfunction

endpackage

@@ rtl/layer_compositor_damage_tracker_unit.sv @@
// Top level of the layered character-cell compositor with damage tracking.
//
// Input stream s_axis: one word per command (write cell, delete cell, commit).
// Output stream m_axis: exactly one result word per accepted command.
// Each layer plane, the pending store and the displayed store sit in RAMs
// with registered reads. A write or delete reads all layer cells and the
// displayed and pending cells at one position, then walks the layers top to
// bottom through one resolve step per cycle, then compares with the
// displayed cell. The result register is loaded as the compare step returns
// to idle, where the next word is taken. A commit finishes in its load step;
// an ignored command goes straight to a null step that loads the result.
// After reset a clearing pass writes zero to every RAM row, one position per
// cycle across all stores at once; s_axis_tready stays low meanwhile.
// The result sits in an output register; a new word is accepted while it waits.
// If the receiver stalls, the next command holds in its final step, before any
// pending or displayed write, until the output register frees up.
module layer_compositor_damage_tracker_unit
    import lcdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // layer[1:0], col[8:2], row[14:9], glyph_bytes[46:15], fg_color[55:47],
    // bg_color[64:56], zero fill [71:65]
    input  logic [71:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_col[6:0], out_row[12:7], out_glyph[44:13], out_fg[53:45],
    // out_bg[62:54], zero fill [63]
    output logic [63:0] m_axis_tdata,
    // changed[0]
    output logic [0:0]  m_axis_tuser
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_NULL = 3'd4;

    localparam int RANK_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    logic [2:0]         r_state;
    logic [1:0]         r_op;
    logic [1:0]         r_layer;
    logic [6:0]         r_col;
    logic [5:0]         r_row;
    t_cell              r_wcell;
    logic [PLANE_W-1:0] r_pos;
    t_cell              r_cells [LAYERS];
    t_cell              r_pix;
    logic               r_found;
    logic [RANK_W-1:0]  r_rank;
    t_cell              r_disp;
    t_cell              r_pend;
    logic               r_out_valid;
    logic [63:0]        r_out_data;
    logic               r_out_user;
    logic               r_clr_busy;
    logic [PLANE_W-1:0] r_clr_addr;

    logic [1:0]         w_in_op;
    logic [1:0]         w_in_layer;
    logic [6:0]         w_in_col;
    logic [5:0]         w_in_row;
    t_cell              w_in_cell;
    logic [PLANE_W-1:0] w_in_pos;
    logic               w_in_bad;
    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic [PLANE_W-1:0] w_raddr;
    logic [PLANE_W-1:0] w_waddr;
    t_cell              w_layer_rd [LAYERS];
    t_cell              w_lane_new [LAYERS];
    logic [LAYERS-1:0]  w_layer_we;
    t_cell              w_pend_rd;
    t_cell              w_disp_rd;
    logic               w_pend_we;
    t_cell              w_pend_wd;
    logic               w_disp_we;
    logic               w_commit_hit;
    t_cell              n_pix;
    logic               n_found;
    t_cell              w_new_pend;
    logic               w_eval_changed;

    assign w_in_op    = s_axis_tuser;
    assign w_in_layer = s_axis_tdata[1:0];
    assign w_in_col   = s_axis_tdata[8:2];
    assign w_in_row   = s_axis_tdata[14:9];
    assign w_in_cell  = '{bg: s_axis_tdata[64:56], fg: s_axis_tdata[55:47],
                          glyph: s_axis_tdata[46:15]};
    assign w_in_pos   = PLANE_W'(w_in_row) * PLANE_W'(COLUMNS) + PLANE_W'(w_in_col);
    assign w_in_bad   = ({1'b0, w_in_col} >= 8'(COLUMNS))
                        || ({1'b0, w_in_row} >= 7'(ROWS))
                        || (w_in_op == OP_NONE)
                        || (w_in_op != OP_COMMIT && {1'b0, w_in_layer} >= 3'(LAYERS));

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_out_load    = w_out_free
                           && ((r_state == S_LOAD && r_op == OP_COMMIT)
                               || (r_state inside {S_CMP, S_NULL}));

    assign w_raddr = (r_state == S_IDLE) ? w_in_pos : r_pos;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_pos;

    // layer planes
    for (genvar k = 0; k < LAYERS; k++) begin : g_layer
        assign w_lane_new[k] = (r_op == OP_WRITE) ? r_wcell : clear_lead(w_layer_rd[k]);
        assign w_layer_we[k] = r_clr_busy
                               || (r_state == S_LOAD && r_op != OP_COMMIT
                                   && r_layer == 2'(k));
        lcdt_ram #(
            .WIDTH (CELL_W),
            .DEPTH (PLANE)
        ) u_layer_ram (
            .i_clk   (i_clk),
            .i_we    (w_layer_we[k]),
            .i_waddr (w_waddr),
            .i_wdata (r_clr_busy ? CELL_W'(0) : w_lane_new[k]),
            .i_raddr (w_raddr),
            .o_rdata (w_layer_rd[k])
        );
    end

    // one resolve step on the cell at the head of the layer shift line
    always_comb begin
        n_pix   = r_pix;
        n_found = r_found;
        if (!r_found) begin
            n_pix   = r_cells[0];
            n_found = (r_cells[0].glyph[7:0] != GLYPH_NONE);
        end else if (r_pix.bg == COLOR_DEFAULT && r_cells[0].glyph[7:0] != GLYPH_NONE) begin
            n_pix.bg = r_cells[0].bg;
        end
    end

    assign w_new_pend     = cells_equal(r_pix, r_disp) ? clear_lead(r_pend) : r_pix;
    assign w_eval_changed = (w_new_pend.glyph[7:0] != GLYPH_NONE);
    assign w_commit_hit   = (w_pend_rd.glyph[7:0] != GLYPH_NONE);

    always_comb begin
        w_pend_we = 1'b0;
        w_pend_wd = '0;
        w_disp_we = 1'b0;
        if (r_clr_busy) begin
            w_pend_we = 1'b1;
            w_disp_we = 1'b1;
        end else if (r_state == S_CMP && w_out_free) begin
            w_pend_we = 1'b1;
            w_pend_wd = w_new_pend;
        end else if (r_state == S_LOAD && r_op == OP_COMMIT && w_out_free && w_commit_hit) begin
            w_pend_we = 1'b1;
            w_pend_wd = clear_lead(w_pend_rd);
            w_disp_we = 1'b1;
        end
    end

    lcdt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (PLANE)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (w_pend_we),
        .i_waddr (w_waddr),
        .i_wdata (w_pend_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_pend_rd)
    );

    lcdt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (PLANE)
    ) u_disp_ram (
        .i_clk   (i_clk),
        .i_we    (w_disp_we),
        .i_waddr (w_waddr),
        .i_wdata (r_clr_busy ? CELL_W'(0) : w_pend_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_disp_rd)
    );

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + PLANE_W'(1);
            if (r_clr_addr == PLANE_W'(PLANE - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_in_bad ? S_NULL : S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_op != OP_COMMIT) begin
                        r_state <= S_SCAN;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_rank == RANK_W'(LAYERS - 1)) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP, S_NULL: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op    <= w_in_op;
                    r_layer <= w_in_layer;
                    r_col   <= w_in_col;
                    r_row   <= w_in_row;
                    r_wcell <= w_in_cell;
                    r_pos   <= w_in_pos;
                end
            end
            S_LOAD: begin
                for (int k = 0; k < LAYERS; k++) begin
                    r_cells[k] <= (r_layer == 2'(k)) ? w_lane_new[k] : w_layer_rd[k];
                end
                r_disp  <= w_disp_rd;
                r_pend  <= w_pend_rd;
                r_pix   <= '0;
                r_found <= 1'b0;
                r_rank  <= '0;
                if (r_op == OP_COMMIT && w_out_free) begin
                    r_out_user <= w_commit_hit;
                    r_out_data <= {1'b0, (w_commit_hit ? w_pend_rd : t_cell'('0)), r_row, r_col};
                end
            end
            S_SCAN: begin
                r_pix   <= n_pix;
                r_found <= n_found;
                r_rank  <= r_rank + RANK_W'(1);
                for (int k = 0; k < LAYERS - 1; k++) begin
                    r_cells[k] <= r_cells[k + 1];
                end
            end
            S_CMP: begin
                if (w_out_free) begin
                    r_out_user <= w_eval_changed;
                    r_out_data <= {1'b0, r_pix, r_row, r_col};
                end
            end
            S_NULL: begin
                if (w_out_free) begin
                    r_out_user <= 1'b0;
                    r_out_data <= {51'd0, r_row, r_col};
                end
            end
            default: begin
                r_rank <= '0;
            end
        endcase
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_accept)
        else $error("word accepted during clearing pass");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOAD || r_state == S_NULL))
        else $error("accepted word did not start a command");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LOAD || $past(r_state) == S_CMP
                                || $past(r_state) == S_NULL))
        else $error("result loaded outside a finishing step");

    a_pend_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pend_we |-> (r_clr_busy || r_state == S_CMP || r_state == S_LOAD))
        else $error("pending store written outside its steps");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rank <= RANK_W'(LAYERS - 1)))
        else $error("layer walk ran past bottom layer");

    a_one_layer_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |-> $onehot0(w_layer_we))
        else $error("more than one layer plane written");
`endif

endmodule

@@ rtl/lcdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/tb_layer_compositor_damage_tracker_unit.sv @@
// Testbench for the layer compositor damage tracker: directed and random cell updates.
`timescale 1ns / 1ps

module tb_layer_compositor_damage_tracker_unit
    import lcdt_pkg::*;
();

    typedef struct packed {
        logic [6:0] col;
        logic [5:0] row;
        logic       changed;
        t_cell      pix;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    t_cell   layer_mem [LAYERS][PLANE];
    t_cell   pending_mem [PLANE];
    t_cell   shown_mem [PLANE];
    t_report damage_reports [$];
    int      errors = 0;
    int      tx_max_gap = 7;
    int      rx_max_stall = 7;

    layer_compositor_damage_tracker_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("layer_compositor_damage_tracker_unit test failed");
        $finish;
    end

    function automatic bit same_on_screen(t_cell a, t_cell b);
        bit glyph_match;
        if (a.glyph[7:0] != b.glyph[7:0]) return 1'b0;
        if (a.glyph[7:0] == GLYPH_NONE) return 1'b1;
        glyph_match = (a.glyph[15:8] == b.glyph[15:8]);
        if (a.glyph[15:8] != GLYPH_NONE) begin
            glyph_match &= (a.glyph[23:16] == b.glyph[23:16])
                           && (a.glyph[23:16] == GLYPH_NONE || a.glyph[31:24] == b.glyph[31:24]);
        end
        return glyph_match && a.bg == b.bg
               && (a.fg == b.fg || a.glyph[7:0] == GLYPH_SPACE);
    endfunction

    function automatic t_report track_damage(logic [1:0] op, logic [1:0] lyr, logic [6:0] col,
                                             logic [5:0] row, logic [31:0] glyph,
                                             logic [8:0] fg, logic [8:0] bg);
        t_report r;
        t_cell   top;
        t_cell   held;
        int      pos;
        int      k;
        r = '0;
        r.col = col;
        r.row = row;
        pos = int'(row) * COLUMNS + int'(col);
        if (op == OP_COMMIT) begin
            held = pending_mem[pos];
            if (held.glyph[7:0] != GLYPH_NONE) begin
                shown_mem[pos] = held;
                pending_mem[pos].glyph[7:0] = GLYPH_NONE;
                r.changed = 1'b1;
                r.pix = held;
            end
        end else if ((op == OP_WRITE || op == OP_DELETE) && int'(lyr) < LAYERS) begin
            if (op == OP_WRITE) layer_mem[lyr][pos] = {bg, fg, glyph};
            else layer_mem[lyr][pos].glyph[7:0] = GLYPH_NONE;
            top = '0;
            k = 0;
            while (k < LAYERS && top.glyph[7:0] == GLYPH_NONE) begin
                top = layer_mem[k][pos];
                k++;
            end
            while (k < LAYERS && top.bg == COLOR_DEFAULT) begin
                if (layer_mem[k][pos].glyph[7:0] != GLYPH_NONE) top.bg = layer_mem[k][pos].bg;
                k++;
            end
            if (!same_on_screen(top, shown_mem[pos])) pending_mem[pos] = top;
            else pending_mem[pos].glyph[7:0] = GLYPH_NONE;
            r.changed = (pending_mem[pos].glyph[7:0] != GLYPH_NONE);
            r.pix = top;
        end
        return r;
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic [1:0] lyr, input logic [6:0] col,
                            input logic [5:0] row, input logic [31:0] glyph,
                            input logic [8:0] fg, input logic [8:0] bg);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, bg, fg, glyph, row, col, lyr};
        do @(posedge i_clk); while (!s_axis_tready);
        damage_reports.push_back(track_damage(op, lyr, col, row, glyph, fg, bg));
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    initial begin
        int      stall;
        t_report want;
        forever begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (damage_reports.size() == 0) begin
                $error("unexpected result word: %0h", m_axis_tdata);
                errors++;
            end else begin
                want = damage_reports.pop_front();
                check_field("out_col", want.col, m_axis_tdata[6:0]);
                check_field("out_row", want.row, m_axis_tdata[12:7]);
                check_field("changed", want.changed, m_axis_tuser[0]);
                check_field("out_glyph", want.pix.glyph, m_axis_tdata[44:13]);
                check_field("out_fg", want.pix.fg, m_axis_tdata[53:45]);
                check_field("out_bg", want.pix.bg, m_axis_tdata[62:54]);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 4))
            0: return GLYPH_NONE;
            1: return GLYPH_SPACE;
            2: return 8'h41 + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_glyph();
        if ($urandom_range(0, 7) == 0) return $urandom();
        return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    endfunction

    function automatic logic [8:0] rand_color();
        case ($urandom_range(0, 3))
            0: return COLOR_DEFAULT;
            1: return 9'($urandom_range(0, 2));
            default: return 9'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic pick_spot(output logic [6:0] col, output logic [5:0] row);
        if ($urandom_range(0, 9) == 0) begin
            col = 7'($urandom_range(0, 127));
            row = 6'($urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 2))
                0: col = 7'd0;
                1: col = 7'd1;
                default: col = 7'd127;
            endcase
            row = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
        end
    endtask

    task automatic test_stack_and_inherit();
        send_cmd(OP_WRITE, 2'd2, 7'd0, 6'd0, 32'h0000_0041, 9'd5, 9'd6);
        send_cmd(OP_COMMIT, 2'd0, 7'd0, 6'd0, '0, '0, '0);
        send_cmd(OP_COMMIT, 2'd0, 7'd0, 6'd0, '0, '0, '0);
        send_cmd(OP_WRITE, 2'd0, 7'd0, 6'd0, 32'hFFFF_FF00, 9'd1, 9'd2);
        send_cmd(OP_WRITE, 2'd1, 7'd0, 6'd0, 32'h0000_0042, COLOR_DEFAULT, COLOR_DEFAULT);
        send_cmd(OP_WRITE, 2'd0, 7'd0, 6'd0, 32'h0000_0020, 9'd1, COLOR_DEFAULT);
        send_cmd(OP_COMMIT, 2'd3, 7'd0, 6'd0, '0, '0, '0);
        send_cmd(OP_WRITE, 2'd0, 7'd0, 6'd0, 32'h0000_0020, 9'd9, COLOR_DEFAULT);
        send_cmd(OP_DELETE, 2'd0, 7'd0, 6'd0, '0, '0, '0);
        send_cmd(OP_DELETE, 2'd1, 7'd0, 6'd0, '0, '0, '0);
        send_cmd(OP_DELETE, 2'd2, 7'd0, 6'd0, '0, '0, '0);
    endtask

    task automatic test_ignored_words();
        send_cmd(OP_NONE, 2'd0, 7'd127, 6'd63, 32'hFFFF_FFFF, 9'h0FF, 9'h0FF);
        send_cmd(OP_WRITE, 2'(LAYERS), 7'd127, 6'd63, 32'hFFFF_FFFF, 9'h0FF, 9'h0FF);
        send_cmd(OP_DELETE, 2'(LAYERS), 7'd127, 6'd63, '0, '0, '0);
        send_cmd(OP_COMMIT, 2'(LAYERS), 7'd127, 6'd63, '0, '0, '0);
    endtask

    task automatic test_glyph_compare();
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'hFFFF_FFFF, 9'h0FF, 9'h0FF);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h1122_00E2, 9'd0, 9'd0);
        send_cmd(OP_COMMIT, 2'd0, 7'd127, 6'd63, '0, '0, '0);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h3344_00E2, 9'd0, 9'd0);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h7733_80E2, 9'd0, 9'd0);
        send_cmd(OP_COMMIT, 2'd0, 7'd127, 6'd63, '0, '0, '0);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h9933_80E2, 9'd0, 9'd0);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h7700_80E2, 9'd0, 9'd0);
        send_cmd(OP_WRITE, 2'd0, 7'd127, 6'd63, 32'h7733_80E2, 9'd0, 9'd0);
    endtask

    task automatic test_random_scenes(input int scenes);
        logic [6:0]  col;
        logic [5:0]  row;
        logic [1:0]  lyr;
        logic [31:0] glyph;
        logic [8:0]  fg;
        logic [8:0]  bg;
        int          steps;
        glyph = rand_glyph();
        fg = rand_color();
        bg = rand_color();
        repeat (scenes) begin
            pick_spot(col, row);
            steps = $urandom_range(1, 5);
            repeat (steps) begin
                lyr = 2'($urandom_range(0, LAYERS - 1));
                if ($urandom_range(0, 3) == 0) begin
                    send_cmd(OP_DELETE, lyr, col, row, '0, '0, '0);
                end else begin
                    case ($urandom_range(0, 4))
                        0: fg = rand_color();
                        1, 2: begin
                            glyph = rand_glyph();
                            fg = rand_color();
                            bg = rand_color();
                        end
                        default: ;
                    endcase
                    send_cmd(OP_WRITE, lyr, col, row, glyph, fg, bg);
                end
            end
            if ($urandom_range(0, 3) != 0) send_cmd(OP_COMMIT, 2'($urandom_range(0, 3)), col, row,
                                                     '0, '0, '0);
        end
    endtask

    task automatic test_random_noise(input int words);
        repeat (words) begin
            send_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                     $urandom(), rand_color(), rand_color());
        end
    endtask

    task automatic test_back_to_back();
        tx_max_gap = 0;
        rx_max_stall = 0;
        test_random_scenes(30);
        rx_max_stall = 7;
        test_random_scenes(30);
        tx_max_gap = 7;
    endtask

    initial begin
        for (int k = 0; k < LAYERS; k++) begin
            for (int p = 0; p < PLANE; p++) layer_mem[k][p] = '0;
        end
        for (int p = 0; p < PLANE; p++) begin
            pending_mem[p] = '0;
            shown_mem[p] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stack_and_inherit();
        test_ignored_words();
        test_glyph_compare();
        test_random_scenes(120);
        test_back_to_back();
        test_random_noise(400);
        test_random_scenes(80);

        s_axis_tvalid <= 1'b0;
        while (damage_reports.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("layer_compositor_damage_tracker_unit test passed");
        end else begin
            $display("layer_compositor_damage_tracker_unit test failed");
        end
        $finish;
    end

endmodule
